// ----- hdl/cies_pkg.sv -----
package cies_pkg;

    typedef enum logic {
        CMD_REQUEST  = 1'b0,
        CMD_BOUNDARY = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ACC_LONG_WRITE  = 2'd0,
        ACC_WORD_WRITE  = 2'd1,
        ACC_VECTOR_READ = 2'd2
    } access_kind_t;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_PC,
        STEP_STATUS,
        STEP_VECTOR
    } step_t;

    localparam logic [2:0]  NMI_LEVEL     = 3'd7;
    localparam logic [15:0] MASK_CLEAR    = 16'hF8FF;
    localparam logic [31:0] VECTOR_BASE   = 32'd96;
    localparam int          VECTOR_SHIFT  = 2;
    localparam logic [31:0] PC_PUSH_SIZE  = 32'd4;
    localparam logic [31:0] FRAME_SIZE    = 32'd6;

    typedef struct packed {
        command_t    command;
        logic [2:0]  level;
        logic [31:0] pc_value;
        logic [31:0] stack_pointer;
        logic [15:0] status_word;
    } in_item_t;

    typedef struct packed {
        access_kind_t access_kind;
        logic [31:0]  bus_address;
        logic [31:0]  write_data;
        logic [15:0]  new_status;
        logic [31:0]  new_stack_pointer;
        logic         last;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] level;
    } pend_t;

endpackage

// ----- hdl/cies_pending.sv -----
module cies_pending
    import cies_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_item_t item,
    output pend_t    pend
);

    pend_t      pend_reg;
    pend_t      pend_next;
    logic [2:0] mask;

    assign mask = item.status_word[10:8];

    always_comb begin
        pend_next = pend_reg;
        if (step) begin
            if (item.command == CMD_REQUEST) begin
                // Level seven is never masked.
                if (item.level > mask || item.level == NMI_LEVEL) begin
                    pend_next.valid = 1'b1;
                    pend_next.level = item.level;
                end
            end else begin
                pend_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    assign pend = pend_reg;

endmodule

// ----- hdl/cies_frame.sv -----
module cies_frame
    import cies_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  logic [2:0] ld_level,
    input  in_item_t  ld_item,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    step_t       step_reg;
    step_t       step_next;
    logic [31:0] pc_reg;
    logic [31:0] sp_pc_reg;
    logic [31:0] sp_new_reg;
    logic [15:0] status_reg;
    logic [15:0] nst_reg;
    logic [31:0] vec_reg;
    logic        take;

    assign take     = m_valid && m_ready;
    assign can_load = (step_reg == STEP_IDLE) || (step_reg == STEP_VECTOR && m_ready);

    always_comb begin
        step_next = step_reg;
        m_valid   = 1'b1;
        m_data.new_status        = nst_reg;
        m_data.new_stack_pointer = sp_new_reg;
        m_data.access_kind       = ACC_LONG_WRITE;
        m_data.bus_address       = sp_pc_reg;
        m_data.write_data        = pc_reg;
        m_data.last              = 1'b0;
        unique case (step_reg)
            STEP_IDLE: begin
                m_valid = 1'b0;
                if (load) begin
                    step_next = STEP_PC;
                end
            end
            STEP_PC: begin
                if (take) begin
                    step_next = STEP_STATUS;
                end
            end
            STEP_STATUS: begin
                m_data.access_kind = ACC_WORD_WRITE;
                m_data.bus_address = sp_new_reg;
                m_data.write_data  = {16'd0, status_reg};
                if (take) begin
                    step_next = STEP_VECTOR;
                end
            end
            STEP_VECTOR: begin
                m_data.access_kind = ACC_VECTOR_READ;
                m_data.bus_address = vec_reg;
                m_data.write_data  = '0;
                m_data.last        = 1'b1;
                if (take) begin
                    step_next = load ? STEP_PC : STEP_IDLE;
                end
            end
            default: begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // Capture the whole exception frame at once.
    always_ff @(posedge aclk) begin
        if (load) begin
            pc_reg     <= ld_item.pc_value;
            sp_pc_reg  <= ld_item.stack_pointer - PC_PUSH_SIZE;
            sp_new_reg <= ld_item.stack_pointer - FRAME_SIZE;
            status_reg <= ld_item.status_word;
            nst_reg    <= (ld_item.status_word & MASK_CLEAR) | {5'd0, ld_level, 8'd0};
            vec_reg    <= VECTOR_BASE + (32'(ld_level) << VECTOR_SHIFT);
        end
    end

endmodule

// ----- hdl/cpu_interrupt_entry_sequencer_core.sv -----
// A serviced boundary's bus ops follow the input register and then the frame step register.
// Throughput: one request per cycle unless a boundary waits for the frame unit; a serviced
// boundary holds the frame unit for three bus ops, one per cycle while m_ready is high.
// Requests and unserviced boundaries produce no result and never stall the input.
// Reset (aresetn low, synchronous): clear the input stage, pending interrupt and frame unit.
module cpu_interrupt_entry_sequencer_core
    import cies_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Input stage: hold one request until it can be processed.
    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t in_item_reg;

    pend_t    pend;
    logic     can_load;
    logic     needs_frame;
    logic     proc;
    logic     load;

    // A boundary with something pending needs the frame unit; everything else
    // only updates the pending state.
    assign needs_frame = (in_item_reg.command == CMD_BOUNDARY) && pend.valid;
    assign proc        = in_valid_reg && (!needs_frame || can_load);
    assign load        = proc && needs_frame;

    // Accept a new request whenever the stage is empty or the held one drains this cycle.
    assign s_ready       = !in_valid_reg || proc;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !proc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Track the pending level; advance it only on a processed request.
    cies_pending u_pending (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc),
        .item    (in_item_reg),
        .pend    (pend)
    );

    // Emit push pc, push status, vector read.
    cies_frame u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .ld_level (pend.level),
        .ld_item  (in_item_reg),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef NO_ASSERTIONS
    a_pc_then_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.access_kind == ACC_LONG_WRITE
        |=> m_valid && m_data.access_kind == ACC_WORD_WRITE)
        else $error("status push did not follow pc push");

    a_service_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> !pend.valid || (in_valid_reg && $past(in_valid_next)))
        else $error("pending interrupt not cleared after service");

    a_status_at_new_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.access_kind == ACC_WORD_WRITE
        |-> m_data.bus_address == m_data.new_stack_pointer)
        else $error("status push address differs from new stack pointer");

    a_last_on_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.access_kind == ACC_VECTOR_READ)))
        else $error("last flag not on vector read");
`endif

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import cies_pkg::*;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // DUT ports; every input starts at a known value
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    cpu_interrupt_entry_sequencer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Requests waiting to be driven, and bus operations the frame logic must still produce
    in_item_t  request_queue[$];
    out_item_t bus_ops_expected[$];

    // Shadow copy of the pending interrupt
    logic       irq_pending = 1'b0;
    logic [2:0] irq_level   = 3'd0;

    // Handshake pressure, in percent of cycles; the stimulus block changes it per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;

    // Update the pending interrupt from a request, or push the three expected frame
    // operations for a boundary that finds one pending.
    task automatic predict_entry(input in_item_t req);
        logic [15:0] entry_status;
        logic [31:0] frame_sp;
        out_item_t   op;
        if (req.command == CMD_REQUEST) begin
            // Level seven is non-maskable; anything else must beat the mask
            if (req.level > req.status_word[10:8] || req.level == NMI_LEVEL) begin
                irq_pending = 1'b1;
                irq_level   = req.level;
            end
        end else if (irq_pending) begin
            entry_status = (req.status_word & MASK_CLEAR) | {5'd0, irq_level, 8'd0};
            frame_sp     = req.stack_pointer - FRAME_SIZE;

            op.new_status        = entry_status;
            op.new_stack_pointer = frame_sp;

            // Push pc as a long word
            op.access_kind = ACC_LONG_WRITE;
            op.bus_address = req.stack_pointer - PC_PUSH_SIZE;
            op.write_data  = req.pc_value;
            op.last        = 1'b0;
            bus_ops_expected.push_back(op);

            // Push the old status as a word
            op.access_kind = ACC_WORD_WRITE;
            op.bus_address = frame_sp;
            op.write_data  = {16'd0, req.status_word};
            bus_ops_expected.push_back(op);

            // Fetch the autovector
            op.access_kind = ACC_VECTOR_READ;
            op.bus_address = VECTOR_BASE + ({29'd0, irq_level} << VECTOR_SHIFT);
            op.write_data  = 32'd0;
            op.last        = 1'b1;
            bus_ops_expected.push_back(op);

            irq_pending = 1'b0;
            irq_level   = 3'd0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Driver: hold valid and payload until accepted, then pick the next request or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_entry(s_data);
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= request_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted bus operation with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bus_ops_expected.size() == 0) begin
                $display("%0t: unexpected bus operation, expected none, got %h", $time, m_data);
                error_count++;
            end else begin
                want = bus_ops_expected.pop_front();
                check_field("access_kind", {30'd0, want.access_kind},
                            {30'd0, m_data.access_kind});
                check_field("bus_address", want.bus_address, m_data.bus_address);
                check_field("write_data", want.write_data, m_data.write_data);
                check_field("new_status", {16'd0, want.new_status},
                            {16'd0, m_data.new_status});
                check_field("new_stack_pointer", want.new_stack_pointer,
                            m_data.new_stack_pointer);
                check_field("last", {31'd0, want.last}, {31'd0, m_data.last});
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic in_item_t make_item(input command_t cmd, input logic [2:0] lvl,
                                           input logic [31:0] pc, input logic [31:0] sp,
                                           input logic [15:0] st);
        in_item_t it;
        it.command       = cmd;
        it.level         = lvl;
        it.pc_value      = pc;
        it.stack_pointer = sp;
        it.status_word   = st;
        return it;
    endfunction

    // Random status word with the interrupt mask forced to a chosen value
    function automatic logic [15:0] status_with_mask(input logic [2:0] mask);
        logic [15:0] st;
        st       = 16'($urandom);
        st[10:8] = mask;
        return st;
    endfunction

    // Queue one request that is sure to be taken: a level above its mask, or level seven
    task automatic queue_live_request();
        logic [2:0] lvl;
        logic [2:0] mask;
        lvl  = 3'($urandom_range(1, 7));
        mask = (lvl == NMI_LEVEL) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, lvl - 1));
        request_queue.push_back(make_item(CMD_REQUEST, lvl, $urandom, $urandom,
                                          status_with_mask(mask)));
    endtask

    task automatic queue_boundary();
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'($urandom), $urandom, $urandom,
                                          16'($urandom)));
    endtask

    // Fill the queue with a mix of well-formed entries and noise
    task automatic queue_random_phase(input int budget);
        int made;
        int pick;
        int burst;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // One to three live requests (later ones replace earlier), then a boundary
                burst = $urandom_range(1, 3);
                repeat (burst) queue_live_request();
                queue_boundary();
                made += burst + 1;
            end else if (pick < 75) begin
                // Request whose level may or may not clear its mask
                request_queue.push_back(make_item(CMD_REQUEST, 3'($urandom), $urandom,
                                                  $urandom, 16'($urandom)));
                made++;
            end else if (pick < 88) begin
                // Lone boundary; often nothing is pending
                queue_boundary();
                made++;
            end else begin
                // Fully random item
                request_queue.push_back(make_item(command_t'($urandom_range(0, 1)),
                                                  3'($urandom), $urandom, $urandom,
                                                  16'($urandom)));
                made++;
            end
        end
    endtask

    task automatic drain_queue();
        while (request_queue.size() != 0) @(posedge aclk);
    endtask

    // Stimulus and end of run
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed entries, no idling
        // Boundary straight after reset: nothing pending
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd5, 32'h1234_5678, 32'h0000_1000,
                                          16'h2700));
        // Level zero never beats the mask
        request_queue.push_back(make_item(CMD_REQUEST, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          16'h0000));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd0, 32'h0000_0100, 32'h0000_2000,
                                          16'h0000));
        // Level seven passes a full mask; boundary wraps the stack below zero
        request_queue.push_back(make_item(CMD_REQUEST, 3'd7, 32'h0, 32'h0, 16'hFFFF));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000,
                                          16'hFFFF));
        // Level equal to the mask is ignored
        request_queue.push_back(make_item(CMD_REQUEST, 3'd3, 32'h0, 32'h0, 16'h0300));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd3, 32'hAAAA_AAAA, 32'h5555_5555,
                                          16'h0300));
        // A later taken request replaces an earlier one, even a higher level
        request_queue.push_back(make_item(CMD_REQUEST, 3'd4, 32'h0, 32'h0, 16'h0300));
        request_queue.push_back(make_item(CMD_REQUEST, 3'd2, 32'h0, 32'h0, 16'h0100));
        // Boundary status differs from the request's; stack wraps partway through the frame
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd7, 32'h0000_0000, 32'h0000_0002,
                                          16'h0000));
        // Request pc and stack fields are don't-care
        request_queue.push_back(make_item(CMD_REQUEST, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          16'hF8FF));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd7, 32'h5555_5555, 32'hFFFF_FFFF,
                                          16'hFFFF));
        // Level six is masked by seven
        request_queue.push_back(make_item(CMD_REQUEST, 3'd6, 32'h0, 32'h0, 16'h0700));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd0, 32'h1, 32'h10, 16'h0700));
        // Taken request, then a second boundary finds nothing left
        request_queue.push_back(make_item(CMD_REQUEST, 3'd5, 32'h0, 32'h0, 16'hFAFF));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd2, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                          16'h0700));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd2, 32'h1, 32'h2, 16'h5555));
        // Level seven under mask zero, back to back with its boundary
        request_queue.push_back(make_item(CMD_REQUEST, 3'd7, 32'h0, 32'h0, 16'h0000));
        request_queue.push_back(make_item(CMD_BOUNDARY, 3'd4, 32'h8000_0000, 32'h8000_0000,
                                          16'hAAAA));
        drain_queue();

        // Random phases: free flow, sender idle, receiver stall, both
        queue_random_phase(113);
        drain_queue();

        send_idle_pct  = 64;
        recv_stall_pct = 0;
        queue_random_phase(113);
        drain_queue();

        send_idle_pct  = 0;
        recv_stall_pct = 64;
        queue_random_phase(113);
        drain_queue();

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        queue_random_phase(113);

        // Wait for the last request to go in, then for every expected operation
        while (request_queue.size() != 0 || s_valid) @(posedge aclk);
        while (bus_ops_expected.size() != 0) @(posedge aclk);
        // Hold a little longer to catch stray operations
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("[cpu_interrupt_entry_sequencer_core] OK");
        end else begin
            $display("[cpu_interrupt_entry_sequencer_core] ERROR");
        end
        $finish;
    end

    // Watchdog: drop the run if it hangs
    initial begin
        #2000000;
        $display("[cpu_interrupt_entry_sequencer_core] ERROR");
        $finish;
    end

endmodule
